### rtl/core/gbrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbrs_pkg
// Shared types and codes of the grid bucketed radius search.
// ----------------------------------------------------------------------------
package gbrs_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OUT   = 2'd1,
		ST_FULL  = 2'd2,
		ST_TRUNC = 2'd3
	} status_t;

	localparam logic [0:0] REG_SCALE_X = 1'b0;
	localparam logic [0:0] REG_SCALE_Y = 1'b1;

endpackage

### rtl/core/grid_bucketed_radius_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bucketed_radius_search_top
// Keypoint store with per-cell linked lists and a fixed-radius query walk.
// ----------------------------------------------------------------------------
// Unused op and add to a full store: result beat straight from idle. Add: result beat
// follows the input beat through scale multiply, cell head/tail read and link write.
// Query: a cell read and check per visited cell, a point read, distance multiply and
// compare per visited point, waiting while a match beat stalls; one item in flight.
// Clear: a sweep of the head/tail memory. Reset clears control state and sweeps the
// head/tail memory before the first beat is accepted.
module grid_bucketed_radius_search_top #(
	parameter int GRID_COLS   = 64,
	parameter int GRID_ROWS   = 48,
	parameter int MAX_POINTS  = 1024,
	parameter int MAX_MATCHES = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op[1:0], pos_x[17:2], pos_y[33:18], radius[49:34], level[52:50],
	// min_level[56:53], max_level[60:57], zero fill
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// point_index[9:0], is_match[10], status[12:11], match_count[18:13], zero fill
	output logic [23:0] m_tdata,
	output logic        m_tlast
);
	localparam int NCELL = GRID_COLS * GRID_ROWS;
	localparam int CW    = (NCELL > 1) ? $clog2(NCELL) : 1;
	localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNTW  = $clog2(MAX_POINTS + 1);
	localparam int XW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int YW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

	typedef enum logic [3:0] {
		S_SWEEP, S_IDLE, S_ADD_MUL, S_ADD_RD, S_ADD_WR, S_Q_MUL, S_Q_WIN,
		S_CELL_RD, S_CELL_CHK, S_PT_RD, S_PT_MUL, S_PT_CMP, S_OUT
	} state_t;

	state_t state_q;
	logic [15:0] scale_x_q, scale_y_q;

	// cell memory: valid, head, tail
	logic [2*PW:0] cell_mem [NCELL];
	logic [2*PW:0] cell_rd_q;
	// point memory: x, y, level, next valid, next
	logic [35+PW:0] pt_mem [MAX_POINTS];
	logic [35+PW:0] pt_rd_q;

	logic [CW-1:0]   cidx_q;
	logic [CNTW-1:0] count_q;
	logic [PW-1:0]   p_q;
	logic [15:0]     qx_q, qy_q, r_q, px_q, py_q;
	logic [2:0]      lvl_q;
	logic signed [3:0] mn_q, mx_q;
	logic [1:0]      op_q;
	logic [39:0]     m0_q, m1_q, m2_q, m3_q;
	logic [31:0]     dx2_q, dy2_q;
	logic [XW-1:0]   x0_q, x1_q, cx_q;
	logic [YW-1:0]   y0_q, y1_q, cy_q;
	logic [5:0]      n_q;
	logic            o_valid_q, o_match_q, o_last_q;
	logic [1:0]      o_status_q;
	logic [PW-1:0]   o_idx_q;
	logic            add_in_q;

	logic [15:0] in_x, in_y, in_r;
	assign in_x = s_tdata[17:2];
	assign in_y = s_tdata[33:18];
	assign in_r = s_tdata[49:34];

	// query window starts at q-r (0 when r covers q), adds at q itself
	logic        in_is_q;
	logic [15:0] in_lo_x, in_lo_y;
	assign in_is_q = (gbrs_pkg::op_t'(s_tdata[1:0]) == gbrs_pkg::OP_QUERY);
	assign in_lo_x = !in_is_q ? in_x : (in_x > in_r) ? 16'(in_x - in_r) : '0;
	assign in_lo_y = !in_is_q ? in_y : (in_y > in_r) ? 16'(in_y - in_r) : '0;

	assign s_tready = (state_q == S_IDLE) && !o_valid_q;
	assign m_tvalid = o_valid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {5'd0, n_q & {6{o_last_q}}, o_status_q, o_match_q,
		10'(o_idx_q)};

	// point decode
	logic [15:0] rd_x, rd_y;
	logic [2:0]  rd_l;
	logic        rd_nv;
	logic [PW-1:0] rd_n;
	assign {rd_x, rd_y, rd_l, rd_nv, rd_n} = pt_rd_q;

	logic lvl_ok;
	always_comb begin
		lvl_ok = 1'b1;
		if (mn_q > 4'sd0 || mx_q >= 4'sd0) begin
			if ($signed({1'b0, rd_l}) < mn_q) lvl_ok = 1'b0;
			if (mx_q >= 4'sd0 && $signed({1'b0, rd_l}) > mx_q) lvl_ok = 1'b0;
		end
	end

	logic [16:0] ad_x, ad_y;
	assign ad_x = (px_q >= qx_q) ? 17'(px_q - qx_q) : 17'(qx_q - px_q);
	assign ad_y = (py_q >= qy_q) ? 17'(py_q - qy_q) : 17'(qy_q - py_q);

	logic [19:0] gx_w, gy_w, wa_x, wa_y, wb_x, wb_y;
	assign gx_w = 20'((m0_q + 40'h80000) >> 20);
	assign gy_w = 20'((m1_q + 40'h80000) >> 20);
	assign wa_x = 20'(m0_q >> 20);
	assign wa_y = 20'(m1_q >> 20);
	assign wb_x = 20'((m2_q + 40'hFFFFF) >> 20);
	assign wb_y = 20'((m3_q + 40'hFFFFF) >> 20);

	logic [CW-1:0] add_cell;
	assign add_cell = CW'(gx_w * GRID_ROWS + gy_w);
	logic [CW-1:0] walk_cell;
	assign walk_cell = CW'(cx_q * GRID_ROWS + cy_q);

	always_ff @(posedge clk) begin
		if (state_q == S_SWEEP) cell_mem[cidx_q] <= '0;
		else if (state_q == S_ADD_WR && add_in_q)
			cell_mem[cidx_q] <= {1'b1,
				cell_rd_q[2*PW] ? cell_rd_q[2*PW-1:PW] : p_q, p_q};
		cell_rd_q <= cell_mem[(state_q == S_ADD_MUL) ? add_cell :
			(state_q == S_CELL_RD) ? walk_cell : cidx_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ADD_MUL)
			pt_mem[p_q] <= {px_q, py_q, lvl_q, 1'b0, PW'(0)};
		else if (state_q == S_ADD_WR && add_in_q && cell_rd_q[2*PW])
			pt_mem[cell_rd_q[PW-1:0]] <= {pt_rd_q[35+PW:PW+1], 1'b1, p_q};
		pt_rd_q <= pt_mem[(state_q == S_ADD_RD) ? cell_rd_q[PW-1:0] : p_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			scale_x_q <= 16'd6554;
			scale_y_q <= 16'd6554;
			cidx_q    <= '0;
			count_q   <= '0;
			o_valid_q <= 1'b0;
			n_q       <= '0;
			op_q      <= gbrs_pkg::OP_NONE;
		end else begin
			if (cfg_we) begin
				if (cfg_index == gbrs_pkg::REG_SCALE_X) scale_x_q <= cfg_data;
				else scale_y_q <= cfg_data;
			end
			if (o_valid_q && m_tready) o_valid_q <= 1'b0;
			unique case (state_q)
				S_SWEEP: begin
					cidx_q <= CW'(cidx_q + 1'b1);
					if (cidx_q == CW'(NCELL - 1)) begin
						state_q <= S_IDLE;
						if (op_q == gbrs_pkg::OP_CLEAR) begin
							o_valid_q <= 1'b1; o_last_q <= 1'b1; o_match_q <= 1'b0;
							o_status_q <= gbrs_pkg::ST_OK; o_idx_q <= '0;
							n_q <= '0;
						end
					end
				end
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q <= s_tdata[1:0];
						px_q <= in_x; py_q <= in_y; qx_q <= in_x; qy_q <= in_y;
						r_q <= in_r; lvl_q <= s_tdata[52:50];
						mn_q <= s_tdata[56:53]; mx_q <= s_tdata[60:57];
						n_q <= '0;
						m0_q <= 40'(in_lo_x * scale_x_q);
						m1_q <= 40'(in_lo_y * scale_y_q);
						m2_q <= 40'((in_x + 17'(in_r)) * scale_x_q);
						m3_q <= 40'((in_y + 17'(in_r)) * scale_y_q);
						unique case (gbrs_pkg::op_t'(s_tdata[1:0]))
							gbrs_pkg::OP_CLEAR: begin
								count_q <= '0; cidx_q <= '0; state_q <= S_SWEEP;
							end
							gbrs_pkg::OP_ADD: begin
								p_q <= PW'(count_q);
								if (count_q >= CNTW'(MAX_POINTS)) begin
									o_valid_q <= 1'b1; o_last_q <= 1'b1;
									o_match_q <= 1'b0; o_idx_q <= '0;
									o_status_q <= gbrs_pkg::ST_FULL;
								end else state_q <= S_ADD_MUL;
							end
							gbrs_pkg::OP_QUERY: begin
								state_q <= S_Q_WIN;
							end
							default: begin
								o_valid_q <= 1'b1; o_last_q <= 1'b1; o_match_q <= 1'b0;
								o_idx_q <= '0; o_status_q <= gbrs_pkg::ST_OK;
							end
						endcase
					end
				end
				S_ADD_MUL: begin
					add_in_q <= (gx_w < 20'(GRID_COLS)) && (gy_w < 20'(GRID_ROWS));
					cidx_q <= add_cell;
					count_q <= CNTW'(count_q + 1'b1);
					state_q <= S_ADD_RD;
				end
				S_ADD_RD: state_q <= S_ADD_WR;
				S_ADD_WR: begin
					o_valid_q <= 1'b1; o_last_q <= 1'b1; o_match_q <= 1'b0;
					o_idx_q <= p_q;
					o_status_q <= add_in_q ? gbrs_pkg::ST_OK : gbrs_pkg::ST_OUT;
					state_q <= S_IDLE;
				end
				S_Q_MUL: state_q <= S_Q_WIN;
				S_Q_WIN: begin
					x0_q <= XW'(wa_x); y0_q <= YW'(wa_y);
					cx_q <= XW'(wa_x); cy_q <= YW'(wa_y);
					x1_q <= (wb_x > 20'(GRID_COLS - 1)) ? XW'(GRID_COLS - 1) : XW'(wb_x);
					y1_q <= (wb_y > 20'(GRID_ROWS - 1)) ? YW'(GRID_ROWS - 1) : YW'(wb_y);
					o_status_q <= gbrs_pkg::ST_OK;
					if ((wa_x < 20'(GRID_COLS)) && (wa_y < 20'(GRID_ROWS)))
						state_q <= S_CELL_RD;
					else state_q <= S_OUT;
				end
				S_CELL_RD: state_q <= S_CELL_CHK;
				S_CELL_CHK: begin
					if (cell_rd_q[2*PW]) begin
						p_q <= cell_rd_q[2*PW-1:PW];
						state_q <= S_PT_RD;
					end else if (cy_q < y1_q) begin
						cy_q <= YW'(cy_q + 1'b1); state_q <= S_CELL_RD;
					end else if (cx_q < x1_q) begin
						cx_q <= XW'(cx_q + 1'b1); cy_q <= y0_q; state_q <= S_CELL_RD;
					end else state_q <= S_OUT;
				end
				S_PT_RD: state_q <= S_PT_MUL;
				S_PT_MUL: begin
					px_q <= rd_x; py_q <= rd_y;
					state_q <= S_PT_CMP;
					dx2_q <= '0;
					dy2_q <= '0;
				end
				S_PT_CMP: begin
					// two-step: the first step squares dx, the second squares dy and compares
					if (dx2_q == '0 && dy2_q != 32'hFFFFFFFF) begin
						dx2_q <= 32'(ad_x * ad_x);
						dy2_q <= 32'hFFFFFFFF;
					end else if (!o_valid_q) begin
						dy2_q <= '0;
						if (lvl_ok && (33'(dx2_q) + 33'(32'(ad_y * ad_y))) <
								33'(r_q * r_q)) begin
							if (n_q >= 6'(MAX_MATCHES)) begin
								o_status_q <= gbrs_pkg::ST_TRUNC;
								state_q <= S_OUT;
							end else begin
								o_valid_q <= 1'b1; o_last_q <= 1'b0; o_match_q <= 1'b1;
								o_idx_q <= p_q; o_status_q <= gbrs_pkg::ST_OK;
								n_q <= 6'(n_q + 1'b1);
							end
						end
						if (!(lvl_ok && n_q >= 6'(MAX_MATCHES) &&
								(33'(dx2_q) + 33'(32'(ad_y * ad_y))) < 33'(r_q * r_q))) begin
							if (rd_nv) begin
								p_q <= rd_n; state_q <= S_PT_RD;
							end else if (cy_q < y1_q) begin
								cy_q <= YW'(cy_q + 1'b1); state_q <= S_CELL_RD;
							end else if (cx_q < x1_q) begin
								cx_q <= XW'(cx_q + 1'b1); cy_q <= y0_q;
								state_q <= S_CELL_RD;
							end else state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (!o_valid_q) begin
						o_valid_q <= 1'b1; o_last_q <= 1'b1; o_match_q <= 1'b0;
						o_idx_q <= '0;
						if (o_status_q != gbrs_pkg::ST_TRUNC) o_status_q <= gbrs_pkg::ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input taken with result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_POINTS))
		else $error("point count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[10]) |-> !m_tlast)
		else $error("match beat marked last");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid bucketed radius search: adds, clears and
// radius queries are streamed in bursts, results are checked beat by beat
// against a bit-accurate model of the store and the cell-window walk.
// ----------------------------------------------------------------------------
module tb;

	localparam int COLS = 64;
	localparam int ROWS = 48;
	localparam int NPTS = 1024;
	localparam int NMATCH = 63;

	typedef struct packed {
		logic [9:0] idx;
		logic       hit;
		logic       last;
		logic [1:0] status;
		logic [5:0] count;
	} beat_t;

	class search_scoreboard;
		logic [15:0] scale_x, scale_y;
		logic [15:0] px [NPTS];
		logic [15:0] py [NPTS];
		logic [2:0]  plv [NPTS];
		int          nxt [NPTS];
		int          head [COLS*ROWS];
		int          tail [COLS*ROWS];
		int          npts;
		beat_t       pending [$];
		int          errors;

		function void init();
			scale_x = 16'd6554;
			scale_y = 16'd6554;
			npts = 0;
			errors = 0;
			foreach (head[i]) head[i] = -1;
		endfunction

		function void push(logic [9:0] i, bit h, bit l, logic [1:0] s, int c);
			beat_t b;
			b.idx = i; b.hit = h; b.last = l; b.status = s; b.count = c[5:0];
			pending = {pending, b};
		endfunction

		function bit axis_window(int q, int r, int sc, int n, output int lo, output int hi);
			longint a, b;
			a = (q <= r) ? 0 : ((longint'(q - r) * sc) >> 20);
			if (a >= n) return 0;
			b = (longint'(q + r) * sc + 64'hFFFFF) >> 20;
			if (b > n - 1) b = n - 1;
			lo = int'(a);
			hi = int'(b);
			return 1;
		endfunction

		function void note_input(gbrs_pkg::op_t op, logic [15:0] x, logic [15:0] y,
				logic [15:0] r, logic [2:0] lv, logic signed [3:0] mn,
				logic signed [3:0] mx);
			int gx, gy, c, p, n, x0, x1, y0, y1;
			bit trunc, chk, ok;
			longint dx, dy, r2;
			case (op)
				gbrs_pkg::OP_CLEAR: begin
					foreach (head[i]) head[i] = -1;
					npts = 0;
					push('0, 0, 1, gbrs_pkg::ST_OK, 0);
				end
				gbrs_pkg::OP_ADD: begin
					if (npts >= NPTS) begin
						push('0, 0, 1, gbrs_pkg::ST_FULL, 0);
					end else begin
						p = npts++;
						px[p] = x; py[p] = y; plv[p] = lv; nxt[p] = -1;
						gx = int'((longint'(x) * scale_x + 64'h80000) >> 20);
						gy = int'((longint'(y) * scale_y + 64'h80000) >> 20);
						if (gx >= COLS || gy >= ROWS) begin
							push(p[9:0], 0, 1, gbrs_pkg::ST_OUT, 0);
						end else begin
							c = gx * ROWS + gy;
							if (head[c] >= 0) nxt[tail[c]] = p;
							else head[c] = p;
							tail[c] = p;
							push(p[9:0], 0, 1, gbrs_pkg::ST_OK, 0);
						end
					end
				end
				gbrs_pkg::OP_QUERY: begin
					n = 0;
					trunc = 0;
					chk = (mn > 0) || (mx >= 0);
					r2 = longint'(r) * r;
					if (axis_window(x, r, scale_x, COLS, x0, x1) &&
							axis_window(y, r, scale_y, ROWS, y0, y1)) begin
						for (int cx = x0; cx <= x1 && !trunc; cx++)
							for (int cy = y0; cy <= y1 && !trunc; cy++) begin
								p = head[cx * ROWS + cy];
								while (p >= 0 && !trunc) begin
									ok = 1;
									if (chk) begin
										if ($signed({2'b0, plv[p]}) < mn) ok = 0;
										if (mx >= 0 && $signed({2'b0, plv[p]}) > mx) ok = 0;
									end
									dx = longint'(px[p]) - longint'(x);
									dy = longint'(py[p]) - longint'(y);
									if (ok && dx * dx + dy * dy < r2) begin
										if (n >= NMATCH) trunc = 1;
										else begin
											push(p[9:0], 1, 0, gbrs_pkg::ST_OK, 0);
											n++;
										end
									end
									p = nxt[p];
								end
							end
					end
					push('0, 0, 1, trunc ? gbrs_pkg::ST_TRUNC : gbrs_pkg::ST_OK, n);
				end
				default: push('0, 0, 1, gbrs_pkg::ST_OK, 0);
			endcase
		endfunction

		function void check_result(logic [23:0] d, logic l);
			beat_t e, a;
			a.idx = d[9:0]; a.hit = d[10]; a.status = d[12:11]; a.count = d[18:13];
			a.last = l;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected beat %h last %b", d, l);
				return;
			end
			e = pending.pop_front();
			if (a !== e || d[23:19] !== 5'd0) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch exp idx %0d hit %b last %b st %0d cnt %0d",
						" / got idx %0d hit %b last %b st %0d cnt %0d"},
						e.idx, e.hit, e.last, e.status, e.count,
						a.idx, a.hit, a.last, a.status, a.count);
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid, s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid, m_tready, m_tlast;
	logic [23:0] m_tdata;
	search_scoreboard sb;
	bit          rx_on;

	grid_bucketed_radius_search_top u_dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#250ms;
		$display("Verification failed");
		$finish;
	end

	// receiver stall pattern: alternating calm and choppy stretches
	initial begin
		int k;
		m_tready = 0;
		k = 0;
		forever begin
			@(posedge clk);
			k++;
			if (rx_on && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
			if ((k / 200) % 3 == 0) m_tready <= 1'b1;
			else m_tready <= ($urandom_range(0, 3) != 0) && (k % 7 != 3);
		end
	end

	int burst;

	// valid stays up across a burst; it drops only for a gap or a drain
	task automatic send(gbrs_pkg::op_t op, logic [15:0] x, logic [15:0] y, logic [15:0] r,
			logic [2:0] lv, logic signed [3:0] mn, logic signed [3:0] mx);
		if (burst == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst = $urandom_range(1, 12);
		end
		burst--;
		s_tvalid <= 1'b1;
		s_tdata <= {3'b0, mx, mn, lv, r, y, x, op};
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, x, y, r, lv, mn, mx);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (3200) @(posedge clk);
	endtask

	task automatic write_scale(logic [0:0] which, logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (which == gbrs_pkg::REG_SCALE_X) sb.scale_x = v;
		else sb.scale_y = v;
	endtask

	function automatic logic signed [3:0] rnd_level_bound();
		return 4'($signed($urandom_range(0, 8)) - 1);
	endfunction

	task automatic random_phase(int cnt, int xmax, int ymax);
		int k;
		logic [15:0] x, y;
		for (int i = 0; i < cnt; i++) begin
			k = $urandom_range(0, 99);
			x = 16'($urandom_range(0, xmax));
			y = 16'($urandom_range(0, ymax));
			if (k < 55)
				send(gbrs_pkg::OP_ADD, x, y, 16'($urandom), 3'($urandom),
					4'($urandom), 4'($urandom));
			else if (k < 92)
				send(gbrs_pkg::OP_QUERY, x, y,
					(k < 60) ? 16'($urandom) : 16'($urandom_range(0, 1200)),
					3'($urandom), rnd_level_bound(), rnd_level_bound());
			else if (k < 96)
				send(gbrs_pkg::OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
					3'($urandom), 4'($urandom), 4'($urandom));
			else
				send(gbrs_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
					3'($urandom), 4'($urandom), 4'($urandom));
		end
	endtask

	initial begin
		sb = new();
		sb.init();
		burst = 0;
		rx_on = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		rx_on = 1;

		// directed
		send(gbrs_pkg::OP_ADD, 16'd0, 16'd0, 16'd0, 3'd0, 4'sd0, 4'sd0);
		send(gbrs_pkg::OP_ADD, 16'd160, 16'd160, 16'hFFFF, 3'd7, -4'sd1, -4'sd1);
		send(gbrs_pkg::OP_ADD, 16'd164, 16'd150, 16'd0, 3'd3, 4'sd0, 4'sd0);
		send(gbrs_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 16'd0, 3'd5, 4'sd0, 4'sd0);
		send(gbrs_pkg::OP_ADD, 16'd7999, 16'd1000, 16'd0, 3'd2, 4'sd0, 4'sd0);
		send(gbrs_pkg::OP_QUERY, 16'd160, 16'd160, 16'd100, 3'd0, -4'sd1, -4'sd1);
		send(gbrs_pkg::OP_QUERY, 16'd160, 16'd160, 16'd100, 3'd0, 4'sd3, 4'sd5);
		send(gbrs_pkg::OP_QUERY, 16'd160, 16'd160, 16'd100, 3'd0, 4'sd0, 4'sd7);
		send(gbrs_pkg::OP_QUERY, 16'd0, 16'd0, 16'd0, 3'd0, -4'sd1, -4'sd1);
		send(gbrs_pkg::OP_QUERY, 16'd0, 16'd0, 16'hFFFF, 3'd0, -4'sd1, -4'sd1);
		send(gbrs_pkg::OP_QUERY, 16'hFFFF, 16'hFFFF, 16'd10, 3'd0, -4'sd1, -4'sd1);
		send(gbrs_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, -4'sd1, 4'sd7);
		for (int i = 0; i < 70; i++)
			send(gbrs_pkg::OP_ADD, 16'(400 + (i % 8)), 16'(400 + i / 8), '0, 3'(i),
				'0, '0);
		send(gbrs_pkg::OP_QUERY, 16'd402, 16'd403, 16'd200, 3'd0, -4'sd1, -4'sd1);
		send(gbrs_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 4'sd7, 4'sd7);
		send(gbrs_pkg::OP_QUERY, 16'd160, 16'd160, 16'd400, 3'd0, -4'sd1, -4'sd1);
		drain();

		// scale settings, extremes included
		write_scale(gbrs_pkg::REG_SCALE_X, 16'hFFFF);
		write_scale(gbrs_pkg::REG_SCALE_Y, 16'd0);
		random_phase(60, 65535, 65535);
		drain();
		write_scale(gbrs_pkg::REG_SCALE_X, 16'd0);
		write_scale(gbrs_pkg::REG_SCALE_Y, 16'hFFFF);
		random_phase(60, 300, 800);
		drain();
		write_scale(gbrs_pkg::REG_SCALE_X, 16'd6554);
		write_scale(gbrs_pkg::REG_SCALE_Y, 16'd6554);
		random_phase(120, 10300, 7700);
		drain();

		write_scale(gbrs_pkg::REG_SCALE_X, 16'd20000);
		write_scale(gbrs_pkg::REG_SCALE_Y, 16'd30000);
		send(gbrs_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0);
		random_phase(50, 3400, 1700);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

### sim.f
rtl/core/gbrs_pkg.sv
rtl/core/grid_bucketed_radius_search_top.sv
test/tb.sv
